[rtl/tds_pkg.sv]
// Shared types, codes and defaults of the task dependency scheduler.
// Used by the channel interfaces, the scheduler core, output buffer and top level.
package tds_pkg;

  // Fixed field widths of the transaction payloads
  localparam int CMD_W    = 3;
  localparam int NODE_W   = 6;
  localparam int STATUS_W = 4;
  localparam int STATE_W  = 3;

  // Defaults for the top-level parameters
  localparam int MAX_NODES_DEF          = 64;
  localparam int MAX_EDGES_PER_NODE_DEF = 8;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_ADD_NODE = 3'd0;
  localparam logic [CMD_W-1:0] CMD_ADD_DEP  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_PREPARE  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_TAKE     = 3'd3;
  localparam logic [CMD_W-1:0] CMD_COMPLETE = 3'd4;
  localparam logic [CMD_W-1:0] CMD_QUERY    = 3'd5;

  // Status codes
  localparam logic [STATUS_W-1:0] STS_OK           = 4'd0;
  localparam logic [STATUS_W-1:0] STS_FULL         = 4'd1;
  localparam logic [STATUS_W-1:0] STS_INVALID      = 4'd2;
  localparam logic [STATUS_W-1:0] STS_DUPLICATE    = 4'd3;
  localparam logic [STATUS_W-1:0] STS_SELF         = 4'd4;
  localparam logic [STATUS_W-1:0] STS_PREPARED     = 4'd5;
  localparam logic [STATUS_W-1:0] STS_NOT_PREPARED = 4'd6;
  localparam logic [STATUS_W-1:0] STS_BAD_STATE    = 4'd7;
  localparam logic [STATUS_W-1:0] STS_CYCLE        = 4'd8;
  localparam logic [STATUS_W-1:0] STS_EMPTY        = 4'd9;

  // Task states
  localparam logic [STATE_W-1:0] TS_PENDING   = 3'd0;
  localparam logic [STATE_W-1:0] TS_READY     = 3'd1;
  localparam logic [STATE_W-1:0] TS_RUNNING   = 3'd2;
  localparam logic [STATE_W-1:0] TS_SUCCEEDED = 3'd3;
  localparam logic [STATE_W-1:0] TS_FAILED    = 3'd4;
  localparam logic [STATE_W-1:0] TS_BLOCKED   = 3'd5;

  // Input transaction
  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [NODE_W-1:0] node;
    logic [NODE_W-1:0] dependency;
    logic              succeeded;
  } tds_in_t;

  // Result transaction
  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [NODE_W-1:0]   node_id;
    logic [STATE_W-1:0]  node_state;
    logic                finished;
    logic                any_failed;
  } tds_res_t;

  // What the shared edge walk does at each dependent
  typedef enum logic [1:0] {
    WM_KAHN,
    WM_SUCC,
    WM_BLOCK
  } tds_walk_t;

  // Sequencer states
  typedef enum logic [4:0] {
    S_IDLE,
    S_DISP,
    S_AD_RA,
    S_AD_RB,
    S_AD_RDY,
    S_AD_SRD,
    S_AD_SCMP,
    S_AD_W1,
    S_AD_W2,
    S_P_RD,
    S_P_WR,
    S_K_WRD,
    S_K_WGET,
    S_T_RD,
    S_T_GET,
    S_T_NRD,
    S_T_NW,
    S_C_RD,
    S_C_CHK,
    S_W_NRD,
    S_W_NGET,
    S_W_DRD,
    S_W_DGET,
    S_W_DM,
    S_B_WRD,
    S_B_WGET,
    S_FIN_RD,
    S_FIN_GET,
    S_RES
  } tds_fsm_t;

endpackage

[rtl/tds_if.sv]
// Valid/ready channel interfaces for input and result transactions.
// Depends on tds_pkg for the payload structs.
interface tds_in_if import tds_pkg::*; ();
  logic    valid;
  logic    ready;
  tds_in_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface tds_out_if import tds_pkg::*; ();
  logic     valid;
  logic     ready;
  tds_res_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[rtl/tds_obuf.sv]
// One-entry output register between the scheduler core and the result channel.
// Depends on tds_pkg for the result struct.
module tds_obuf import tds_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  tds_res_t in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output tds_res_t out_data
);

  logic     full_r;
  logic     full_nxt;
  tds_res_t data_r;

  assign in_ready  = !full_r || out_ready;
  assign out_valid = full_r;
  assign out_data  = data_r;

  // occupancy
  always_comb begin
    full_nxt = full_r;
    if (in_valid && in_ready) begin
      full_nxt = 1'b1;
    end else if (out_ready) begin
      full_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      full_r <= 1'b0;
    end else begin
      full_r <= full_nxt;
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      data_r <= in_data;
    end
  end

endmodule

[rtl/tds_core.sv]
// Scheduler sequencer with node, edge, ready-queue and worklist memories.
// Depends on tds_pkg; one transaction is processed at a time.
module tds_core import tds_pkg::*; #(
  parameter int MAX_NODES          = MAX_NODES_DEF,
  parameter int MAX_EDGES_PER_NODE = MAX_EDGES_PER_NODE_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  tds_in_t  in_data,
  output logic     res_valid,
  input  logic     res_ready,
  output tds_res_t res_data
);

  localparam int N     = MAX_NODES;
  localparam int E     = MAX_EDGES_PER_NODE;
  localparam int NIW   = $clog2(N);
  localparam int CW    = $clog2(N + 1);
  localparam int EW    = $clog2(E + 1);
  localparam int LW    = $clog2(N * E);
  localparam int CMPW  = NODE_W + CW + NIW;
  localparam int SLOTS = N * E;

  typedef struct packed {
    logic [STATE_W-1:0] state;
    logic [EW-1:0]      dc;
    logic [EW-1:0]      dnc;
    logic [EW-1:0]      unf;
  } node_ent_t;

  function automatic logic is_node(input logic [CMPW-1:0] n, input logic [CW-1:0] tot);
    return n < CMPW'(tot);
  endfunction

  function automatic logic [LW-1:0] eaddr(input logic [NIW-1:0] n, input logic [EW-1:0] k);
    return LW'(n) * LW'(E) + LW'(k);
  endfunction

  // memories
  node_ent_t        node_mem [N];
  logic [NIW-1:0]   dep_mem  [SLOTS];
  logic [NIW-1:0]   dnt_mem  [SLOTS];
  logic [NIW-1:0]   rf_mem   [N];
  logic [NIW-1:0]   wl_mem   [N];

  logic             nm_we;
  logic [NIW-1:0]   nm_waddr, nm_raddr;
  node_ent_t        nm_wdata, nm_rd_r;
  logic             ep_we;
  logic [LW-1:0]    dep_waddr, dnt_waddr, dep_raddr, dnt_raddr;
  logic [NIW-1:0]   dep_wdata, dnt_wdata, dep_rd_r, dnt_rd_r;
  logic             rf_we;
  logic [NIW-1:0]   rf_waddr, rf_raddr, rf_wdata, rf_rd_r;
  logic             wl_we;
  logic [NIW-1:0]   wl_waddr, wl_raddr, wl_wdata, wl_rd_r;

  // control and payload registers
  tds_fsm_t            state_r, state_nxt;
  logic [CW-1:0]       node_total_r, node_total_nxt;
  logic [CW-1:0]       head_r, head_nxt;
  logic [CW-1:0]       tail_r, tail_nxt;
  logic [CW-1:0]       term_r, term_nxt;
  logic                prepared_r, prepared_nxt;
  logic                failed_r, failed_nxt;
  logic [CW-1:0]       kh_r, kh_nxt;
  logic [CW-1:0]       kc_r, kc_nxt;
  logic [CW-1:0]       top_r, top_nxt;
  logic [CW-1:0]       pi_r, pi_nxt;
  logic                fill_r, fill_nxt;
  tds_walk_t           mode_r, mode_nxt;

  logic [CMD_W-1:0]    cmd_r, cmd_nxt;
  logic [NODE_W-1:0]   nd_r, nd_nxt;
  logic [NODE_W-1:0]   dp_r, dp_nxt;
  logic                ok_r, ok_nxt;
  logic [STATUS_W-1:0] st_r, st_nxt;
  logic [NODE_W-1:0]   nout_r, nout_nxt;
  logic [STATE_W-1:0]  nstate_r, nstate_nxt;
  node_ent_t           ent_a_r, ent_a_nxt;
  node_ent_t           ent_b_r, ent_b_nxt;
  logic [EW-1:0]       i_r, i_nxt;
  logic [EW-1:0]       dnc_r, dnc_nxt;
  logic [NIW-1:0]      wn_r, wn_nxt;
  logic [NIW-1:0]      wd_r, wd_nxt;

  // shared conditions
  logic nd_ok, dp_ok, ad_more, ad_full, dup_hit, p_more, k_more, w_more, d_ok, run_ok;
  logic take_empty;

  assign nd_ok      = is_node(CMPW'(nd_r), node_total_r);
  assign dp_ok      = is_node(CMPW'(dp_r), node_total_r);
  assign ad_more    = i_r < ent_a_r.dc;
  assign ad_full    = (ent_a_r.dc >= EW'(E)) || (ent_b_r.dnc >= EW'(E));
  assign dup_hit    = dep_rd_r == NIW'(dp_r);
  assign p_more     = pi_r < node_total_r;
  assign k_more     = kh_r < kc_r;
  assign w_more     = i_r < dnc_r;
  assign d_ok       = is_node(CMPW'(dnt_rd_r), node_total_r);
  assign run_ok     = nm_rd_r.state == TS_RUNNING;
  assign take_empty = (head_r >= tail_r) || (head_r >= CW'(N));

  assign in_ready  = state_r == S_IDLE;
  assign res_valid = state_r == S_RES;
  assign res_data  = '{status:     st_r,
                       node_id:    nout_r,
                       node_state: nstate_r,
                       finished:   prepared_r && (term_r == node_total_r),
                       any_failed: failed_r};

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:    if (in_valid) state_nxt = S_DISP;
      S_DISP: begin
        priority case (cmd_r)
          CMD_ADD_NODE: begin
            if (prepared_r || node_total_r >= CW'(N)) state_nxt = S_FIN_RD;
            else state_nxt = S_RES;
          end
          CMD_ADD_DEP: begin
            if (!nd_ok || !dp_ok || prepared_r || nd_r == dp_r) state_nxt = S_FIN_RD;
            else state_nxt = S_AD_RA;
          end
          CMD_PREPARE: state_nxt = prepared_r ? S_FIN_RD : S_P_RD;
          CMD_TAKE:    state_nxt = (!prepared_r || take_empty) ? S_FIN_RD : S_T_RD;
          CMD_COMPLETE: state_nxt = (!prepared_r || !nd_ok) ? S_FIN_RD : S_C_RD;
          default:     state_nxt = S_FIN_RD;
        endcase
      end
      S_AD_RA:   state_nxt = S_AD_RB;
      S_AD_RB:   state_nxt = S_AD_RDY;
      S_AD_RDY:  state_nxt = S_AD_SRD;
      S_AD_SRD: begin
        if (ad_more) state_nxt = S_AD_SCMP;
        else if (ad_full) state_nxt = S_FIN_RD;
        else state_nxt = S_AD_W1;
      end
      S_AD_SCMP: state_nxt = dup_hit ? S_FIN_RD : S_AD_SRD;
      S_AD_W1:   state_nxt = S_AD_W2;
      S_AD_W2:   state_nxt = S_FIN_RD;
      S_P_RD: begin
        if (p_more) state_nxt = S_P_WR;
        else if (!fill_r) state_nxt = S_K_WRD;
        else state_nxt = S_FIN_RD;
      end
      S_P_WR:    state_nxt = S_P_RD;
      S_K_WRD: begin
        if (k_more) state_nxt = S_K_WGET;
        else if (kh_r == node_total_r) state_nxt = S_P_RD;
        else state_nxt = S_FIN_RD;
      end
      S_K_WGET:  state_nxt = S_W_NRD;
      S_T_RD:    state_nxt = S_T_GET;
      S_T_GET:   state_nxt = S_T_NRD;
      S_T_NRD:   state_nxt = S_T_NW;
      S_T_NW:    state_nxt = S_RES;
      S_C_RD:    state_nxt = S_C_CHK;
      S_C_CHK:   state_nxt = run_ok ? S_W_NRD : S_FIN_RD;
      S_W_NRD:   state_nxt = S_W_NGET;
      S_W_NGET:  state_nxt = S_W_DRD;
      S_W_DRD: begin
        if (w_more) state_nxt = S_W_DGET;
        else begin
          unique case (mode_r)
            WM_KAHN: state_nxt = S_K_WRD;
            WM_SUCC: state_nxt = S_FIN_RD;
            default: state_nxt = (top_r == '0) ? S_FIN_RD : S_B_WRD;
          endcase
        end
      end
      S_W_DGET:  state_nxt = d_ok ? S_W_DM : S_W_DRD;
      S_W_DM:    state_nxt = S_W_DRD;
      S_B_WRD:   state_nxt = S_B_WGET;
      S_B_WGET:  state_nxt = S_W_NRD;
      S_FIN_RD:  state_nxt = nd_ok ? S_FIN_GET : S_RES;
      S_FIN_GET: state_nxt = S_RES;
      S_RES:     if (res_ready) state_nxt = S_IDLE;
      default:   state_nxt = S_IDLE;
    endcase
  end

  // datapath and memory controls
  always_comb begin
    node_ent_t e;
    logic [EW-1:0] u;

    node_total_nxt = node_total_r;
    head_nxt = head_r;
    tail_nxt = tail_r;
    term_nxt = term_r;
    prepared_nxt = prepared_r;
    failed_nxt = failed_r;
    kh_nxt = kh_r;
    kc_nxt = kc_r;
    top_nxt = top_r;
    pi_nxt = pi_r;
    fill_nxt = fill_r;
    mode_nxt = mode_r;
    cmd_nxt = cmd_r;
    nd_nxt = nd_r;
    dp_nxt = dp_r;
    ok_nxt = ok_r;
    st_nxt = st_r;
    nout_nxt = nout_r;
    nstate_nxt = nstate_r;
    ent_a_nxt = ent_a_r;
    ent_b_nxt = ent_b_r;
    i_nxt = i_r;
    dnc_nxt = dnc_r;
    wn_nxt = wn_r;
    wd_nxt = wd_r;

    nm_we = 1'b0;
    nm_waddr = '0;
    nm_wdata = '0;
    nm_raddr = '0;
    ep_we = 1'b0;
    dep_waddr = '0;
    dnt_waddr = '0;
    dep_wdata = '0;
    dnt_wdata = '0;
    dep_raddr = '0;
    dnt_raddr = '0;
    rf_we = 1'b0;
    rf_waddr = '0;
    rf_wdata = '0;
    rf_raddr = '0;
    wl_we = 1'b0;
    wl_waddr = '0;
    wl_wdata = '0;
    wl_raddr = '0;
    e = nm_rd_r;
    u = '0;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd_nxt  = in_data.cmd;
          nd_nxt   = in_data.node;
          dp_nxt   = in_data.dependency;
          ok_nxt   = in_data.succeeded;
          st_nxt   = STS_OK;
          nout_nxt = '0;
        end
      end
      S_DISP: begin
        priority case (cmd_r)
          CMD_ADD_NODE: begin
            if (prepared_r) st_nxt = STS_PREPARED;
            else if (node_total_r >= CW'(N)) st_nxt = STS_FULL;
            else begin
              nm_we          = 1'b1;
              nm_waddr       = NIW'(node_total_r);
              nm_wdata       = '{state: TS_PENDING, dc: '0, dnc: '0, unf: '0};
              nout_nxt       = NODE_W'(node_total_r);
              nstate_nxt     = TS_PENDING;
              node_total_nxt = node_total_r + 1'b1;
            end
          end
          CMD_ADD_DEP: begin
            if (!nd_ok || !dp_ok) st_nxt = STS_INVALID;
            else if (prepared_r) st_nxt = STS_PREPARED;
            else if (nd_r == dp_r) st_nxt = STS_SELF;
          end
          CMD_PREPARE: begin
            if (prepared_r) st_nxt = STS_PREPARED;
            else begin
              pi_nxt   = '0;
              kc_nxt   = '0;
              kh_nxt   = '0;
              fill_nxt = 1'b0;
            end
          end
          CMD_TAKE: begin
            if (!prepared_r) st_nxt = STS_NOT_PREPARED;
            else if (take_empty) st_nxt = STS_EMPTY;
          end
          CMD_COMPLETE: begin
            if (!prepared_r) st_nxt = STS_NOT_PREPARED;
            else if (!nd_ok) st_nxt = STS_INVALID;
          end
          CMD_QUERY: begin
            if (!nd_ok) st_nxt = STS_INVALID;
          end
          default: st_nxt = STS_BAD_STATE;
        endcase
      end
      // add dependency: fetch both entries, scan for a duplicate, then append
      S_AD_RA:  nm_raddr = NIW'(nd_r);
      S_AD_RB: begin
        nm_raddr  = NIW'(dp_r);
        ent_a_nxt = nm_rd_r;
      end
      S_AD_RDY: begin
        ent_b_nxt = nm_rd_r;
        i_nxt     = '0;
      end
      S_AD_SRD: begin
        if (ad_more) dep_raddr = eaddr(NIW'(nd_r), i_r);
        else if (ad_full) st_nxt = STS_FULL;
      end
      S_AD_SCMP: begin
        if (dup_hit) st_nxt = STS_DUPLICATE;
        else i_nxt = i_r + 1'b1;
      end
      S_AD_W1: begin
        ep_we     = 1'b1;
        dep_waddr = eaddr(NIW'(nd_r), ent_a_r.dc);
        dep_wdata = NIW'(dp_r);
        dnt_waddr = eaddr(NIW'(dp_r), ent_b_r.dnc);
        dnt_wdata = NIW'(nd_r);
        nm_we     = 1'b1;
        nm_waddr  = NIW'(nd_r);
        nm_wdata  = ent_a_r;
        nm_wdata.dc = ent_a_r.dc + 1'b1;
      end
      S_AD_W2: begin
        nm_we    = 1'b1;
        nm_waddr = NIW'(dp_r);
        nm_wdata = ent_b_r;
        nm_wdata.dnc = ent_b_r.dnc + 1'b1;
      end
      // node sweep: in-degree seed (first pass) or ready fill (second pass)
      S_P_RD: begin
        if (p_more) nm_raddr = NIW'(pi_r);
        else if (fill_r) prepared_nxt = 1'b1;
      end
      S_P_WR: begin
        e.unf = nm_rd_r.dc;
        if (!fill_r) begin
          if (nm_rd_r.dc == '0 && kc_r < CW'(N)) begin
            wl_we    = 1'b1;
            wl_waddr = NIW'(kc_r);
            wl_wdata = NIW'(pi_r);
            kc_nxt   = kc_r + 1'b1;
          end
        end else if (nm_rd_r.dc == '0) begin
          e.state = TS_READY;
          if (tail_r < CW'(N)) begin
            rf_we    = 1'b1;
            rf_waddr = NIW'(tail_r);
            rf_wdata = NIW'(pi_r);
            tail_nxt = tail_r + 1'b1;
          end
        end
        nm_we    = 1'b1;
        nm_waddr = NIW'(pi_r);
        nm_wdata = e;
        pi_nxt   = pi_r + 1'b1;
      end
      S_K_WRD: begin
        if (k_more) wl_raddr = NIW'(kh_r);
        else if (kh_r == node_total_r) begin
          fill_nxt = 1'b1;
          pi_nxt   = '0;
        end else st_nxt = STS_CYCLE;
      end
      S_K_WGET: begin
        wn_nxt   = wl_rd_r;
        kh_nxt   = kh_r + 1'b1;
        mode_nxt = WM_KAHN;
      end
      // take ready
      S_T_RD: rf_raddr = NIW'(head_r);
      S_T_GET: begin
        nout_nxt = NODE_W'(rf_rd_r);
        wn_nxt   = rf_rd_r;
        head_nxt = head_r + 1'b1;
      end
      S_T_NRD: nm_raddr = wn_r;
      S_T_NW: begin
        e.state    = TS_RUNNING;
        nm_we      = 1'b1;
        nm_waddr   = wn_r;
        nm_wdata   = e;
        nstate_nxt = TS_RUNNING;
      end
      // complete
      S_C_RD: nm_raddr = NIW'(nd_r);
      S_C_CHK: begin
        if (!run_ok) st_nxt = STS_BAD_STATE;
        else begin
          e.state  = ok_r ? TS_SUCCEEDED : TS_FAILED;
          nm_we    = 1'b1;
          nm_waddr = NIW'(nd_r);
          nm_wdata = e;
          term_nxt = term_r + 1'b1;
          wn_nxt   = NIW'(nd_r);
          top_nxt  = '0;
          mode_nxt = ok_r ? WM_SUCC : WM_BLOCK;
          if (!ok_r) failed_nxt = 1'b1;
        end
      end
      // walk the dependents of node wn
      S_W_NRD: nm_raddr = wn_r;
      S_W_NGET: begin
        dnc_nxt = nm_rd_r.dnc;
        i_nxt   = '0;
      end
      S_W_DRD: begin
        if (w_more) dnt_raddr = eaddr(wn_r, i_r);
      end
      S_W_DGET: begin
        wd_nxt = dnt_rd_r;
        if (d_ok) nm_raddr = dnt_rd_r;
        else i_nxt = i_r + 1'b1;
      end
      S_W_DM: begin
        i_nxt    = i_r + 1'b1;
        nm_waddr = wd_r;
        unique case (mode_r)
          WM_KAHN: begin
            if (nm_rd_r.unf != '0) begin
              u        = nm_rd_r.unf - 1'b1;
              e.unf    = u;
              nm_we    = 1'b1;
              nm_wdata = e;
              if (u == '0 && kc_r < CW'(N)) begin
                wl_we    = 1'b1;
                wl_waddr = NIW'(kc_r);
                wl_wdata = wd_r;
                kc_nxt   = kc_r + 1'b1;
              end
            end
          end
          WM_SUCC: begin
            if (nm_rd_r.state == TS_PENDING) begin
              u     = (nm_rd_r.unf != '0) ? nm_rd_r.unf - 1'b1 : nm_rd_r.unf;
              e.unf = u;
              if (u == '0) begin
                e.state = TS_READY;
                if (tail_r < CW'(N)) begin
                  rf_we    = 1'b1;
                  rf_waddr = NIW'(tail_r);
                  rf_wdata = wd_r;
                  tail_nxt = tail_r + 1'b1;
                end
              end
              nm_we    = 1'b1;
              nm_wdata = e;
            end
          end
          default: begin
            if (nm_rd_r.state != TS_BLOCKED && nm_rd_r.state != TS_SUCCEEDED &&
                nm_rd_r.state != TS_FAILED) begin
              e.state  = TS_BLOCKED;
              nm_we    = 1'b1;
              nm_wdata = e;
              term_nxt = term_r + 1'b1;
              if (top_r < CW'(N)) begin
                wl_we    = 1'b1;
                wl_waddr = NIW'(top_r);
                wl_wdata = wd_r;
                top_nxt  = top_r + 1'b1;
              end
            end
          end
        endcase
      end
      // pop the block worklist
      S_B_WRD: begin
        wl_raddr = NIW'(top_r - 1'b1);
        top_nxt  = top_r - 1'b1;
      end
      S_B_WGET: wn_nxt = wl_rd_r;
      // state of the node field after the step
      S_FIN_RD: begin
        if (nd_ok) nm_raddr = NIW'(nd_r);
        else nstate_nxt = TS_BLOCKED;
      end
      S_FIN_GET: nstate_nxt = nm_rd_r.state;
      S_RES: ;
      default: ;
    endcase
  end

  // memories: one write and one registered read each
  always_ff @(posedge clk) begin
    if (nm_we) node_mem[nm_waddr] <= nm_wdata;
    nm_rd_r <= node_mem[nm_raddr];
  end

  always_ff @(posedge clk) begin
    if (ep_we) begin
      dep_mem[dep_waddr] <= dep_wdata;
      dnt_mem[dnt_waddr] <= dnt_wdata;
    end
    dep_rd_r <= dep_mem[dep_raddr];
    dnt_rd_r <= dnt_mem[dnt_raddr];
  end

  always_ff @(posedge clk) begin
    if (rf_we) rf_mem[rf_waddr] <= rf_wdata;
    rf_rd_r <= rf_mem[rf_raddr];
  end

  always_ff @(posedge clk) begin
    if (wl_we) wl_mem[wl_waddr] <= wl_wdata;
    wl_rd_r <= wl_mem[wl_raddr];
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      node_total_r <= '0;
      head_r       <= '0;
      tail_r       <= '0;
      term_r       <= '0;
      prepared_r   <= 1'b0;
      failed_r     <= 1'b0;
      kh_r         <= '0;
      kc_r         <= '0;
      top_r        <= '0;
      pi_r         <= '0;
      fill_r       <= 1'b0;
      mode_r       <= WM_KAHN;
    end else begin
      state_r      <= state_nxt;
      node_total_r <= node_total_nxt;
      head_r       <= head_nxt;
      tail_r       <= tail_nxt;
      term_r       <= term_nxt;
      prepared_r   <= prepared_nxt;
      failed_r     <= failed_nxt;
      kh_r         <= kh_nxt;
      kc_r         <= kc_nxt;
      top_r        <= top_nxt;
      pi_r         <= pi_nxt;
      fill_r       <= fill_nxt;
      mode_r       <= mode_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    cmd_r    <= cmd_nxt;
    nd_r     <= nd_nxt;
    dp_r     <= dp_nxt;
    ok_r     <= ok_nxt;
    st_r     <= st_nxt;
    nout_r   <= nout_nxt;
    nstate_r <= nstate_nxt;
    ent_a_r  <= ent_a_nxt;
    ent_b_r  <= ent_b_nxt;
    i_r      <= i_nxt;
    dnc_r    <= dnc_nxt;
    wn_r     <= wn_nxt;
    wd_r     <= wd_nxt;
  end

endmodule

[rtl/task_dependency_scheduler.sv]
// Top level of the task dependency scheduler: core sequencer plus output register.
// Depends on tds_pkg, tds_if, tds_core and tds_obuf.
//
//   channel | dir | handshake    | payload
//   in_ch   | in  | valid/ready  | cmd, node, dependency, succeeded
//   out_ch  | out | valid/ready  | status, node_id, node_state, finished, any_failed
//
// One transaction at a time; one result per input transaction.
// Query and errors read back the state of the node when the node field names a node.
// Add dependency scans every existing dependency of the node for a duplicate.
// Complete walks the dependent edges; a failure also walks every transitively blocked node.
// Prepare sweeps the nodes, walks the dependent edges in Kahn order, then sweeps again.
// rst_n is synchronous; memories are not cleared. A stalled result is held in the
// output register while the next transaction is accepted and processed.
module task_dependency_scheduler import tds_pkg::*; #(
  parameter int MAX_NODES          = MAX_NODES_DEF,
  parameter int MAX_EDGES_PER_NODE = MAX_EDGES_PER_NODE_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  tds_in_if.sink    in_ch,
  tds_out_if.source out_ch
);

  logic     res_valid;
  logic     res_ready;
  tds_res_t res_data;

  tds_core #(
    .MAX_NODES          (MAX_NODES),
    .MAX_EDGES_PER_NODE (MAX_EDGES_PER_NODE)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .in_data   (in_ch.data),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_data  (res_data)
  );

  tds_obuf u_obuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (res_valid),
    .in_ready  (res_ready),
    .in_data   (res_data),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_data  (out_ch.data)
  );

endmodule
